// ----- hw/rtl/snhs_pkg.sv -----
package snhs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [2*WORD_BITS+1:0] prod_t;

	localparam word_t V_INIT = -word_t'(70 <<< FRAC_BITS);
	localparam word_t U_INIT = -word_t'(14 <<< FRAC_BITS);
	localparam word_t K004 = word_t'(((4 <<< FRAC_BITS) + 50) / 100);
	localparam word_t K140 = word_t'(140 <<< FRAC_BITS);
	localparam word_t V_THRESH = word_t'(30 <<< FRAC_BITS);

	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_B = 3'd1;
	localparam logic [2:0] REG_C = 3'd2;
	localparam logic [2:0] REG_D = 3'd3;
	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_TE = 3'd5;
	localparam logic [2:0] REG_TI = 3'd6;
	localparam logic [2:0] REG_EIN = 3'd7;

	// saturate a wide exact sum to the word
	function automatic word_t sat_w(input logic signed [39:0] x);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		begin
			hi = 40'sd2147483647;
			lo = -40'sd2147483648;
			if (x > hi) sat_w = word_t'(hi);
			else if (x < lo) sat_w = word_t'(lo);
			else sat_w = x[WORD_BITS-1:0];
		end
	endfunction

	// product >> FRAC_BITS (or FRAC_BITS+1), half away from zero, saturated
	function automatic word_t fround(input prod_t p, input logic half);
		logic neg;
		logic [2*WORD_BITS+1:0] mag;
		logic [2*WORD_BITS+1:0] rnd;
		logic [2*WORD_BITS+1:0] m;
		logic [2*WORD_BITS+1:0] lim;
		begin
			neg = p[2*WORD_BITS+1];
			mag = neg ? $unsigned(-p) : $unsigned(p);
			if (half) begin
				rnd = mag + ((2*WORD_BITS+2)'(1) << FRAC_BITS);
				m = rnd >> (FRAC_BITS + 1);
			end else begin
				rnd = mag + ((2*WORD_BITS+2)'(1) << (FRAC_BITS - 1));
				m = rnd >> FRAC_BITS;
			end
			lim = neg ? ((2*WORD_BITS+2)'(1) << (WORD_BITS - 1))
				: (((2*WORD_BITS+2)'(1) << (WORD_BITS - 1)) - 1'b1);
			if (m > lim) m = lim;
			fround = neg ? word_t'(-m) : word_t'(m);
		end
	endfunction

endpackage

// ----- hw/rtl/spiking_neuron_heun_step_unit.sv -----
// Izhikevich neuron, conductance synapses, one Heun step per input word.
// Each word runs 24 microcode steps on one shared 33x33 multiplier, each step
// in two phases (multiply into a register, then round/saturate/write back).
// No new word is taken before the last step (tready returns the cycle after
// it; the last step waits while the previous output word is unaccepted).
// Reset (arst_n low, async): registers to defaults, v=-70, u=-14, ge=gi=0, idle.
module spiking_neuron_heun_step_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// injected_current, noise_excite, noise_inhibit, syn_excite_sum,
	// syn_inhibit_sum, 2 zero bits
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// spiked, voltage_out, recovery_out, excite_cond_out, inhibit_cond_out,
	// net_current, 1 zero bit
	output logic [159:0] m_tdata
);
	import snhs_pkg::*;

	// microcode steps: stage-0 decay terms, stage-0 derivative, Euler
	// predictor, stage-1 derivative, stage-1 decay terms, trapezoid update
	localparam logic [4:0] ST_KGE0 = 5'd0;
	localparam logic [4:0] ST_KGI0 = 5'd1;
	localparam logic [4:0] ST_GEV0 = 5'd2;
	localparam logic [4:0] ST_GIV0 = 5'd3;
	localparam logic [4:0] ST_VV0 = 5'd4;
	localparam logic [4:0] ST_QD0 = 5'd5;
	localparam logic [4:0] ST_BV0 = 5'd6;
	localparam logic [4:0] ST_FU0 = 5'd7;
	localparam logic [4:0] ST_PV = 5'd8;
	localparam logic [4:0] ST_PU = 5'd9;
	localparam logic [4:0] ST_PGE = 5'd10;
	localparam logic [4:0] ST_PGI = 5'd11;
	localparam logic [4:0] ST_GEV1 = 5'd12;
	localparam logic [4:0] ST_GIV1 = 5'd13;
	localparam logic [4:0] ST_VV1 = 5'd14;
	localparam logic [4:0] ST_QD1 = 5'd15;
	localparam logic [4:0] ST_BV1 = 5'd16;
	localparam logic [4:0] ST_FU1 = 5'd17;
	localparam logic [4:0] ST_KGE1 = 5'd18;
	localparam logic [4:0] ST_KGI1 = 5'd19;
	localparam logic [4:0] ST_FGE = 5'd20;
	localparam logic [4:0] ST_FGI = 5'd21;
	localparam logic [4:0] ST_FV = 5'd22;
	localparam logic [4:0] ST_FU = 5'd23;

	// configuration registers
	logic [16:0] a_q, h_q, te_q, ti_q;
	logic signed [17:0] b_q;
	logic signed [23:0] c_q, ein_q;
	logic signed [22:0] d_q;

	// neuron state (stage-0 values) and stage-1 predictor values
	word_t sv_q, su_q, sge_q, sgi_q;
	word_t wv_q, wu_q, wge_q, wgi_q;
	// derivative terms and temporaries
	word_t kge0_q, kgi0_q, kge1_q, kgi1_q;
	word_t kv0_q, ku0_q, kv1_q, ku1_q, cur_q;
	word_t gev_q, giv_q, tmp_q, quad_q;
	// latched input word
	word_t inj_q, ne_q, ni_q;
	logic [30:0] se_q, si_q;

	// sequencer
	logic busy_q, ph_q;
	logic [4:0] step_q;
	prod_t prod_s1;

	// output register
	logic out_valid_q;
	logic [159:0] out_q;

	logic in_fire, last_fire, wb_en, stage1, half;
	logic signed [32:0] opa, opb;
	word_t xv, xu, xge, xgi, r, c_v, fv_v, g1, g2, vfin, ufin;
	logic signed [39:0] isyn;

	assign s_tready = !busy_q;
	assign in_fire = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	assign stage1 = (step_q >= ST_GEV1);
	assign xv = stage1 ? wv_q : sv_q;
	assign xu = stage1 ? wu_q : su_q;
	assign xge = stage1 ? wge_q : sge_q;
	assign xgi = stage1 ? wgi_q : sgi_q;
	assign half = (step_q >= ST_FGE);

	// operand select for the shared multiplier
	always_comb begin
		opa = 33'sd0;
		opb = 33'sd0;
		case (step_q)
			ST_KGE0: begin opa = 33'(sge_q); opb = 33'($signed({1'b0, te_q})); end
			ST_KGI0: begin opa = 33'(sgi_q); opb = 33'($signed({1'b0, ti_q})); end
			ST_GEV0, ST_GEV1: begin opa = 33'(xge); opb = 33'(xv); end
			ST_GIV0, ST_GIV1: begin opa = 33'(xgi); opb = 33'(tmp_q); end
			ST_VV0, ST_VV1: begin opa = 33'(xv); opb = 33'(xv); end
			ST_QD0, ST_QD1: begin opa = 33'(K004); opb = 33'(tmp_q); end
			ST_BV0, ST_BV1: begin opa = 33'(b_q); opb = 33'(xv); end
			ST_FU0, ST_FU1: begin opa = 33'($signed({1'b0, a_q})); opb = 33'(tmp_q); end
			ST_PV: begin opa = 33'($signed({1'b0, h_q})); opb = 33'(kv0_q); end
			ST_PU: begin opa = 33'($signed({1'b0, h_q})); opb = 33'(ku0_q); end
			ST_PGE: begin opa = 33'($signed({1'b0, h_q})); opb = 33'(kge0_q); end
			ST_PGI: begin opa = 33'($signed({1'b0, h_q})); opb = 33'(kgi0_q); end
			ST_KGE1: begin opa = 33'(wge_q); opb = 33'($signed({1'b0, te_q})); end
			ST_KGI1: begin opa = 33'(wgi_q); opb = 33'($signed({1'b0, ti_q})); end
			ST_FGE: begin
				opa = 33'($signed({1'b0, h_q}));
				opb = 33'(kge0_q) + 33'(kge1_q);
			end
			ST_FGI: begin
				opa = 33'($signed({1'b0, h_q}));
				opb = 33'(kgi0_q) + 33'(kgi1_q);
			end
			ST_FV: begin
				opa = 33'($signed({1'b0, h_q}));
				opb = 33'(kv0_q) + 33'(kv1_q);
			end
			ST_FU: begin
				opa = 33'($signed({1'b0, h_q}));
				opb = 33'(ku0_q) + 33'(ku1_q);
			end
			default: begin opa = 33'sd0; opb = 33'sd0; end
		endcase
	end

	// write-back arithmetic on the registered product
	always_comb begin
		r = fround(prod_s1, half);
		isyn = 40'(sat_w(40'(gev_q) + 40'(giv_q)));
		c_v = sat_w(40'(inj_q) - isyn);
		fv_v = sat_w(40'(quad_q) + 40'(xv) * 40'sd5 + 40'(K140) - 40'(xu) + 40'(c_v));
		g1 = sat_w(40'(stage1 && step_q == ST_FGI ? sgi_q : sge_q)
			+ 40'(step_q == ST_FGI ? ni_q : ne_q) + 40'(r));
		g2 = sat_w(40'(g1) + 40'($signed({9'd0, (step_q == ST_FGI) ? si_q : se_q})));
		if (g2 < 0) g2 = '0;
		ufin = sat_w(40'(su_q) + 40'(r));
		vfin = sv_q;
	end

	assign wb_en = busy_q && ph_q && (step_q != ST_FU || !out_valid_q || m_tready);
	assign last_fire = wb_en && (step_q == ST_FU);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 17'd1311;
			b_q <= 18'sd13107;
			c_q <= -24'sd4259840;
			d_q <= 23'sd524288;
			h_q <= 17'd6554;
			te_q <= 17'd13107;
			ti_q <= 17'd10923;
			ein_q <= -24'sd5242880;
			sv_q <= V_INIT;
			su_q <= U_INIT;
			sge_q <= '0;
			sgi_q <= '0;
			busy_q <= 1'b0;
			ph_q <= 1'b0;
			step_q <= ST_KGE0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_A: a_q <= cfg_data[16:0];
					REG_B: b_q <= cfg_data[17:0];
					REG_C: c_q <= cfg_data[23:0];
					REG_D: d_q <= cfg_data[22:0];
					REG_H: h_q <= cfg_data[16:0];
					REG_TE: te_q <= cfg_data[16:0];
					REG_TI: ti_q <= cfg_data[16:0];
					REG_EIN: ein_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			// a new word may land in the same cycle the old one leaves
			if (last_fire) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			if (in_fire) begin
				busy_q <= 1'b1;
				ph_q <= 1'b0;
				step_q <= ST_KGE0;
			end else if (busy_q && !ph_q) begin
				ph_q <= 1'b1;
			end else if (wb_en) begin
				ph_q <= 1'b0;
				if (last_fire) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
			if (wb_en) begin
				case (step_q)
					ST_FGE: sge_q <= g2;
					ST_FGI: sgi_q <= g2;
					ST_FV: sv_q <= sat_w(40'(sv_q) + 40'(r));
					ST_FU: begin
						// threshold crossing: reset v, bump u
						if (vfin >= V_THRESH) begin
							sv_q <= word_t'(c_q);
							su_q <= sat_w(40'(ufin) + 40'(d_q));
						end else begin
							su_q <= ufin;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			inj_q <= s_tdata[31:0];
			ne_q <= s_tdata[63:32];
			ni_q <= s_tdata[95:64];
			se_q <= s_tdata[126:96];
			si_q <= s_tdata[157:127];
		end
		if (busy_q && !ph_q) prod_s1 <= 66'(opa) * 66'(opb);
		if (wb_en) begin
			case (step_q)
				ST_KGE0: kge0_q <= sat_w(-40'(r));
				ST_KGI0: kgi0_q <= sat_w(-40'(r));
				ST_GEV0, ST_GEV1: begin
					gev_q <= r;
					tmp_q <= sat_w(40'(xv) - 40'(ein_q));
				end
				ST_GIV0, ST_GIV1: giv_q <= r;
				ST_VV0, ST_VV1: tmp_q <= r;
				ST_QD0, ST_QD1: quad_q <= r;
				ST_BV0, ST_BV1: tmp_q <= sat_w(40'(r) - 40'(xu));
				ST_FU0: begin kv0_q <= fv_v; ku0_q <= r; end
				ST_FU1: begin kv1_q <= fv_v; ku1_q <= r; cur_q <= c_v; end
				ST_PV: wv_q <= sat_w(40'(sv_q) + 40'(r));
				ST_PU: wu_q <= sat_w(40'(su_q) + 40'(r));
				ST_PGE: wge_q <= sat_w(40'(sge_q) + 40'(ne_q) + 40'(r));
				ST_PGI: wgi_q <= sat_w(40'(sgi_q) + 40'(ni_q) + 40'(r));
				ST_KGE1: kge1_q <= sat_w(-40'(r));
				ST_KGI1: kgi1_q <= sat_w(-40'(r));
				default: ;
			endcase
		end
		if (last_fire) begin
			out_q[0] <= (vfin >= V_THRESH);
			out_q[32:1] <= (vfin >= V_THRESH) ? word_t'(c_q) : vfin;
			out_q[64:33] <= (vfin >= V_THRESH) ? sat_w(40'(ufin) + 40'(d_q)) : ufin;
			out_q[95:65] <= sge_q[30:0];
			out_q[126:96] <= sgi_q[30:0];
			out_q[158:127] <= cur_q;
			out_q[159] <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("accepted a word while busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= ST_FU)
		else $error("sequencer step out of range");
	a_spike_reset: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && out_q[0]) |-> out_q[32:1] == word_t'(c_q))
		else $error("spike without voltage reset");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the Heun-step Izhikevich neuron.
// The sender offers one tick word at a time. At each accepted word the neuron
// predictor advances its own copy of v, u, ge and gi and queues the expected
// output word. The receiver process pops one expectation per accepted output
// word and compares every field.
module tb_top;
	import snhs_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [23:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;

	spiking_neuron_heun_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// one expected output word
	typedef struct {
		bit          spiked;
		logic [31:0] volt;
		logic [31:0] recov;
		logic [30:0] gexc;
		logic [30:0] ginh;
		logic [31:0] icur;
	} neuron_word_t;

	neuron_word_t tick_expect_q[$];

	// predictor copy of the registers (sign-extended) and the neuron state
	longint par[8];
	longint st_v, st_u, st_ge, st_gi;

	int  n_errors;
	int  n_sent;
	int  n_checked;
	int  n_spikes;
	bit  quiet;          // no random idling on either side while set
	int  hold_req;       // receiver hold-off request, in cycles
	int  hold_left;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam int REG_W[8] = '{17, 18, 24, 23, 17, 17, 17, 24};
	localparam bit REG_S[8] = '{0, 1, 1, 1, 0, 0, 0, 1};

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint sat_word(longint x);
		if (x > WMAX) return WMAX;
		if (x < WMIN) return WMIN;
		return x;
	endfunction

	// (x*y) >> sh, half away from zero, saturated to the word
	function automatic longint mul_round(longint x, longint y, int sh);
		logic [127:0] ux;
		logic [127:0] uy;
		logic [127:0] p;
		logic [127:0] lim;
		bit neg;
		neg = (x < 0) != (y < 0);
		ux = 128'(x < 0 ? -x : x);
		uy = 128'(y < 0 ? -y : y);
		p = ux * uy + (128'd1 << (sh - 1));
		p = p >> sh;
		lim = neg ? 128'd2147483648 : 128'd2147483647;
		if (p > lim) p = lim;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// dv/dt, du/dt and the net current at one point
	function automatic void neuron_slope(input longint v, u, ge, gi, inj,
			output longint fv, fu, cur);
		longint isyn, quad;
		isyn = sat_word(mul_round(ge, v, FRAC_BITS)
			+ mul_round(gi, sat_word(v - par[REG_EIN]), FRAC_BITS));
		cur = sat_word(inj - isyn);
		quad = mul_round(longint'(K004), mul_round(v, v, FRAC_BITS), FRAC_BITS);
		fv = sat_word(quad + 5 * v + longint'(K140) - u + cur);
		fu = mul_round(par[REG_A], sat_word(mul_round(par[REG_B], v, FRAC_BITS) - u),
			FRAC_BITS);
	endfunction

	// advance the neuron by one tick and return the output word it yields
	function automatic neuron_word_t heun_tick(logic [159:0] w);
		longint inj, ne, ni, se, si, h, te, ti;
		longint kge0, kgi0, kge1, kgi1, kv0, ku0, kv1, ku1, cur0, cur1;
		longint v1, u1, ge1, gi1, v, u, ge, gi;
		neuron_word_t r;
		inj = longint'($signed(w[31:0]));
		ne  = longint'($signed(w[63:32]));
		ni  = longint'($signed(w[95:64]));
		se  = longint'(w[126:96]);
		si  = longint'(w[157:127]);
		h = par[REG_H]; te = par[REG_TE]; ti = par[REG_TI];

		// first stage: slopes at the start of the step
		kge0 = sat_word(-mul_round(st_ge, te, FRAC_BITS));
		kgi0 = sat_word(-mul_round(st_gi, ti, FRAC_BITS));
		neuron_slope(st_v, st_u, st_ge, st_gi, inj, kv0, ku0, cur0);
		v1  = sat_word(st_v + mul_round(h, kv0, FRAC_BITS));
		u1  = sat_word(st_u + mul_round(h, ku0, FRAC_BITS));
		// predictor conductances are left unclamped
		ge1 = sat_word(st_ge + ne + mul_round(h, kge0, FRAC_BITS));
		gi1 = sat_word(st_gi + ni + mul_round(h, kgi0, FRAC_BITS));

		// second stage and the averaged update
		neuron_slope(v1, u1, ge1, gi1, inj, kv1, ku1, cur1);
		kge1 = sat_word(-mul_round(ge1, te, FRAC_BITS));
		kgi1 = sat_word(-mul_round(gi1, ti, FRAC_BITS));
		v  = sat_word(st_v + mul_round(h, kv0 + kv1, FRAC_BITS + 1));
		u  = sat_word(st_u + mul_round(h, ku0 + ku1, FRAC_BITS + 1));
		ge = sat_word(st_ge + ne + mul_round(h, kge0 + kge1, FRAC_BITS + 1));
		gi = sat_word(st_gi + ni + mul_round(h, kgi0 + kgi1, FRAC_BITS + 1));

		// synaptic increments, then no negative conductance
		ge = sat_word(ge + se);
		gi = sat_word(gi + si);
		if (ge < 0) ge = 0;
		if (gi < 0) gi = 0;

		r.spiked = 1'b0;
		if (v >= longint'(V_THRESH)) begin
			v = sat_word(par[REG_C]);
			u = sat_word(u + par[REG_D]);
			r.spiked = 1'b1;
		end
		st_v = v; st_u = u; st_ge = ge; st_gi = gi;

		r.volt  = v[31:0];
		r.recov = u[31:0];
		r.gexc  = ge[30:0];
		r.ginh  = gi[30:0];
		r.icur  = cur1[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		n_errors++;
	endtask

	// receiver: random tready, long hold-offs on request, checks each word
	always @(posedge clk or negedge arst_n) begin
		neuron_word_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (tick_expect_q.size() == 0) begin
					report_mismatch("unexpected word", longint'(m_tdata[63:0]), 0);
				end else begin
					e = tick_expect_q.pop_front();
					n_checked++;
					if (e.spiked) n_spikes++;
					if (m_tdata[0] !== e.spiked) report_mismatch("spiked", m_tdata[0], e.spiked);
					if (m_tdata[32:1] !== e.volt) report_mismatch("voltage_out", m_tdata[32:1], e.volt);
					if (m_tdata[64:33] !== e.recov)
						report_mismatch("recovery_out", m_tdata[64:33], e.recov);
					if (m_tdata[95:65] !== e.gexc)
						report_mismatch("excite_cond_out", m_tdata[95:65], e.gexc);
					if (m_tdata[126:96] !== e.ginh)
						report_mismatch("inhibit_cond_out", m_tdata[126:96], e.ginh);
					if (m_tdata[158:127] !== e.icur)
						report_mismatch("net_current", m_tdata[158:127], e.icur);
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// offer one tick word; returns once it is accepted
	task automatic send_tick(logic [31:0] inj, logic [31:0] ne, logic [31:0] ni,
			logic [30:0] se, logic [30:0] si);
		if (!quiet && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, si, se, ni, ne, inj};
		do @(posedge clk); while (!s_tready);
		tick_expect_q.insert(tick_expect_q.size(), heun_tick({2'b00, si, se, ni, ne, inj}));
		n_sent++;
	endtask

	task automatic send_rand_tick();
		if ($urandom_range(0, 4) == 0)
			send_tick($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
		else
			send_tick(32'($signed($urandom_range(0, 40 << 16)) - (10 << 16)),
				32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)),
				32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)),
				31'($urandom_range(0, 1 << 16)), 31'($urandom_range(0, 1 << 16)));
	endtask

	// lower valid and wait until every expected word has come back
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tick_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write; block must be idle, caller drops the write enable
	task automatic write_reg(logic [2:0] idx, longint value);
		longint m;
		m = value & ((64'sd1 <<< REG_W[idx]) - 1);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= m[23:0];
		@(posedge clk);
		if (REG_S[idx] && m[REG_W[idx]-1]) m = m - (64'sd1 <<< REG_W[idx]);
		par[idx] = m;
	endtask

	task automatic write_all(longint a, b, c, d, h, te, ti, ein);
		drain_outputs();
		write_reg(REG_A, a);
		write_reg(REG_B, b);
		write_reg(REG_C, c);
		write_reg(REG_D, d);
		write_reg(REG_H, h);
		write_reg(REG_TE, te);
		write_reg(REG_TI, ti);
		write_reg(REG_EIN, ein);
		cfg_we <= 1'b0;
	endtask

	// default registers: field extremes and the equilibrium start
	task automatic test_field_extremes();
		send_tick(32'h0, 32'h0, 32'h0, 31'h0, 31'h0);
		send_tick(32'h7fffffff, 32'h0, 32'h0, 31'h0, 31'h0);
		send_tick(32'h80000000, 32'h0, 32'h0, 31'h0, 31'h0);
		send_tick(32'h0, 32'h7fffffff, 32'h80000000, 31'h0, 31'h0);
		send_tick(32'h0, 32'h80000000, 32'h7fffffff, 31'h0, 31'h0);
		send_tick(32'h0, 32'h0, 32'h0, 31'h7fffffff, 31'h7fffffff);
		send_tick(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 31'h0);
		send_tick(32'h0, 32'hffff0000, 32'hffff0000, 31'h0, 31'h0);
		drain_outputs();
	endtask

	// drive the cell over threshold a few times
	task automatic test_spike_reset();
		write_all(1311, 13107, -4259840, 524288, 6554, 13107, 10923, -5242880);
		repeat (12) send_tick(32'(40 << 16), 32'h0, 32'h0, 31'h0, 31'h0);
		send_tick(32'h7fffffff, 32'h0, 32'h0, 31'h0, 31'h0);
		drain_outputs();
	endtask

	// register extremes, including a zero step that freezes the dynamics
	task automatic test_register_extremes();
		write_all(0, -65536, -8388608, -2097152, 65536, 1, 1, -8388608);
		repeat (4) send_rand_tick();
		write_all(65536, 65536, 0, 2097152, 1, 65536, 65536, 0);
		repeat (4) send_rand_tick();
		write_all(1311, 13107, -4259840, 524288, 0, 13107, 10923, -5242880);
		send_tick(32'(5 << 16), 32'(1 << 16), 32'hffff0000, 31'(1 << 15), 31'h0);
		send_tick(32'(5 << 16), 32'hfff00000, 32'h0, 31'h0, 31'(1 << 15));
		drain_outputs();
	endtask

	// random configurations and ticks, one stretch with no idling
	task automatic test_random_ticks();
		for (int ph = 0; ph < 4; ph++) begin
			write_all($urandom_range(0, 65536), longint'($urandom_range(0, 131072)) - 65536,
				-longint'($urandom_range(0, 8388608)),
				longint'($urandom_range(0, 4194304)) - 2097152,
				$urandom_range(1, 65536), $urandom_range(1, 65536), $urandom_range(1, 65536),
				-longint'($urandom_range(0, 8388608)));
			if (ph == 2) quiet = 1'b1;
			repeat (100) send_rand_tick();
			quiet = 1'b0;
		end
		drain_outputs();
	endtask

	// receiver holds off long enough that the input stalls
	task automatic test_backpressure();
		write_all(1311, 13107, -4259840, 524288, 6554, 13107, 10923, -5242880);
		hold_req = 400;
		quiet = 1'b1;
		repeat (20) send_rand_tick();
		quiet = 1'b0;
		drain_outputs();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0;
		n_errors = 0; n_sent = 0; n_checked = 0; n_spikes = 0;
		quiet = 1'b0; hold_req = 0;
		par = '{1311, 13107, -4259840, 524288, 6554, 13107, 10923, -5242880};
		st_v = longint'(V_INIT); st_u = longint'(U_INIT); st_ge = 0; st_gi = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_spike_reset();
		test_register_extremes();
		test_random_ticks();
		test_backpressure();

		repeat (60) @(posedge clk);
		$display("ran %0d ticks, %0d words checked, %0d spikes, over %0d register settings",
			n_sent, n_checked, n_spikes, 9);
		if (n_errors == 0 && tick_expect_q.size() == 0) begin
			$display("** spiking_neuron_heun_step_unit: PASSED **");
		end else begin
			$display("%0d errors, %0d words never arrived", n_errors, tick_expect_q.size());
			$display("** spiking_neuron_heun_step_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d words outstanding", tick_expect_q.size());
		$display("** spiking_neuron_heun_step_unit: FAILED **");
		$finish;
	end

endmodule
